[rtl/core/twr_pkg.sv]
package twr_pkg;

    localparam int TS_W   = 40;
    localparam int ID_W   = 8;
    localparam int ACC_W  = 86;
    localparam int DEN_W  = 42;
    localparam int CNT_W  = 7;

    // micrometres per tick scaled by 2^32
    localparam logic [ACC_W-1:0] UM_SCALE = ACC_W'(64'd20150972848706);

    // frame types
    localparam logic [2:0] MSG_INIT   = 3'd0;
    localparam logic [2:0] MSG_REPLY1 = 3'd1;
    localparam logic [2:0] MSG_REPLY2 = 3'd2;
    localparam logic [2:0] MSG_REPORT = 3'd3;
    localparam logic [2:0] MSG_FAILED = 3'd4;

    // input operations
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TX_DONE = 2'd1;
    localparam logic [1:0] OP_FRAME   = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_RANGE    = 3'd1;
    localparam logic [2:0] EV_REPORT   = 3'd2;
    localparam logic [2:0] EV_FAILED   = 3'd3;
    localparam logic [2:0] EV_UNEXP    = 3'd4;
    localparam logic [2:0] EV_MISMATCH = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ID      = 2'd0;
    localparam logic [1:0] CFG_REPLY_DELAY = 2'd1;
    localparam logic [1:0] CFG_RESET_MS    = 2'd2;

    // stamp store slots
    localparam int S_INIT_TX = 0;
    localparam int S_INIT_RX = 1;
    localparam int S_R1_TX   = 2;
    localparam int S_R1_RX   = 3;
    localparam int S_R2_TX   = 4;
    localparam int S_R2_RX   = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANGE,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL_A,
        PH_MUL_B,
        PH_SUB,
        PH_DIV,
        PH_SCALE,
        PH_DONE
    } range_phase_t;

    typedef struct packed {
        logic            tx_request;
        logic [2:0]      tx_type;
        logic [ID_W-1:0] tx_target;
        logic            tx_delayed;
        logic [TS_W-1:0] tx_word_a;
        logic [TS_W-1:0] tx_word_b;
        logic [TS_W-1:0] tx_word_c;
        logic [2:0]      event_code;
        logic [31:0]     dist_um;
        logic [TS_W-1:0] tof_ticks;
    } result_t;

    typedef struct packed {
        logic        done;
        logic [TS_W-1:0] tof;
        logic [31:0] um;
    } range_status_t;

endpackage

[rtl/core/twr_range.sv]
module twr_range (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [twr_pkg::TS_W-1:0] round1,
    input  logic [twr_pkg::TS_W-1:0] round2,
    input  logic [twr_pkg::TS_W-1:0] reply1,
    input  logic [twr_pkg::TS_W-1:0] reply2,
    output twr_pkg::range_status_t  status
);
    import twr_pkg::*;

    range_phase_t     phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mcand_reg, mcand_next;
    logic [TS_W-1:0]  mplier_reg, mplier_next;
    logic [TS_W-1:0]  rp1_reg, rp1_next;
    logic [TS_W-1:0]  rp2_reg, rp2_next;
    logic [2*TS_W-1:0] pa_reg, pa_next;
    logic [2*TS_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [TS_W-1:0]  quo_reg, quo_next;

    // shared adder
    logic [ACC_W-1:0] add_a, add_b;
    logic             add_cin;
    logic [ACC_W:0]   add_sum;
    logic             add_carry;
    logic [ACC_W-1:0] acc_upd;
    logic [TS_W-1:0]  quo_upd;

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (phase_reg)
            PH_MUL_A, PH_MUL_B, PH_SCALE:
            begin
                add_a = acc_reg;
                add_b = mcand_reg;
            end
            PH_SUB:
            begin
                add_a   = ACC_W'(pa_reg);
                add_b   = ~ACC_W'(acc_reg[2*TS_W-1:0]);
                add_cin = 1'b1;
            end
            PH_DIV:
            begin
                add_a   = ACC_W'({rem_reg, num_reg[2*TS_W-1]});
                add_b   = ~ACC_W'(den_reg);
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (ACC_W+1)'(add_cin);
    assign add_carry = add_sum[ACC_W];
    assign acc_upd   = mplier_reg[0] ? add_sum[ACC_W-1:0] : acc_reg;
    assign quo_upd   = {quo_reg[TS_W-2:0], add_carry};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
                if (start)
                    phase_next = PH_MUL_A;
            PH_MUL_A:
                if (cnt_reg == CNT_W'(TS_W-1))
                    phase_next = PH_MUL_B;
            PH_MUL_B:
                if (cnt_reg == CNT_W'(TS_W-1))
                    phase_next = PH_SUB;
            PH_SUB:
                if (add_carry && den_reg != '0)
                    phase_next = PH_DIV;
                else
                    phase_next = PH_SCALE;
            PH_DIV:
                if (cnt_reg == CNT_W'(2*TS_W-1))
                    phase_next = PH_SCALE;
            PH_SCALE:
                if (cnt_reg == CNT_W'(TS_W-1))
                    phase_next = PH_DONE;
            PH_DONE:
                phase_next = PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rp1_next    = rp1_reg;
        rp2_next    = rp2_reg;
        pa_next     = pa_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        case (phase_reg)
            PH_IDLE:
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(round1);
                    mplier_next = round2;
                    rp1_next    = reply1;
                    rp2_next    = reply2;
                    cnt_next    = '0;
                    den_next    = DEN_W'(round1) + DEN_W'(round2)
                                + DEN_W'(reply1) + DEN_W'(reply2);
                end
            PH_MUL_A, PH_MUL_B, PH_SCALE:
            begin
                acc_next    = acc_upd;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[TS_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TS_W-1))
                begin
                    cnt_next = '0;
                    if (phase_reg == PH_MUL_A)
                    begin
                        pa_next     = acc_upd[2*TS_W-1:0];
                        acc_next    = '0;
                        mcand_next  = ACC_W'(rp1_reg);
                        mplier_next = rp2_reg;
                    end
                end
            end
            PH_SUB:
            begin
                num_next = add_sum[2*TS_W-1:0];
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
                if (!(add_carry && den_reg != '0))
                begin
                    // negative numerator or empty denominator
                    acc_next    = ACC_W'(64'h8000_0000);
                    mcand_next  = UM_SCALE;
                    mplier_next = '0;
                end
            end
            PH_DIV:
            begin
                rem_next = add_carry ? add_sum[DEN_W-1:0]
                                     : {rem_reg[DEN_W-2:0], num_reg[2*TS_W-1]};
                quo_next = quo_upd;
                num_next = {num_reg[2*TS_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(2*TS_W-1))
                begin
                    cnt_next    = '0;
                    acc_next    = ACC_W'(64'h8000_0000);
                    mcand_next  = UM_SCALE;
                    mplier_next = quo_upd;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rp1_reg    <= rp1_next;
        rp2_reg    <= rp2_next;
        pa_reg     <= pa_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    // outputs
    always_comb
    begin
        status.done = (phase_reg == PH_DONE);
        status.tof  = quo_reg;
        status.um   = (acc_reg[ACC_W-1:64] != '0) ? 32'hFFFF_FFFF : acc_reg[63:32];
    end

endmodule

[rtl/core/two_way_ranging_protocol_engine_core.sv]
// Double-sided two-way ranging engine. One event is taken per transfer on the
// input channel (request, transmit done, received frame, millisecond tick) and
// yields at most one result transfer: a transmit command and/or an event code.
// An event without a result leaves the input ready. An event with a result shows it
// the cycle after acceptance. A REPLY2 that completes an exchange first runs the
// time-of-flight arithmetic on one shared 86-bit adder: two 40-step shift-add
// products, one subtract, an 80-step restoring divide and a 40-step scale to
// micrometres, then a done phase (no divide for a negative numerator or zero
// denominator). The input stalls from acceptance until the result
// is taken. Configuration writes are always ready and should happen while idle.
module two_way_ranging_protocol_engine_core (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [twr_pkg::TS_W-1:0] cfg_data,
    // input events
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [2:0]               msg_type,
    input  logic [twr_pkg::ID_W-1:0] sender_id,
    input  logic [twr_pkg::ID_W-1:0] target_id,
    input  logic [twr_pkg::TS_W-1:0] stamp,
    input  logic [twr_pkg::TS_W-1:0] payload_a,
    input  logic [twr_pkg::TS_W-1:0] payload_b,
    input  logic [twr_pkg::TS_W-1:0] payload_c,
    input  logic [twr_pkg::ID_W-1:0] requested_peer,
    // results
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     tx_request,
    output logic [2:0]               tx_type,
    output logic [twr_pkg::ID_W-1:0] tx_target,
    output logic                     tx_delayed,
    output logic [twr_pkg::TS_W-1:0] tx_word_a,
    output logic [twr_pkg::TS_W-1:0] tx_word_b,
    output logic [twr_pkg::TS_W-1:0] tx_word_c,
    output logic [2:0]               event_code,
    output logic [31:0]              dist_um,
    output logic [twr_pkg::TS_W-1:0] tof_ticks
);
    import twr_pkg::*;

    // configuration registers
    logic [ID_W-1:0] own_id_reg;
    logic [TS_W-1:0] reply_delay_reg;
    logic [15:0]     reset_ms_reg;

    // protocol state
    ctrl_state_t     state_reg, state_next;
    logic [2:0]      exp_reg, exp_next;
    logic [2:0]      last_tx_reg, last_tx_next;
    logic [ID_W-1:0] partner_reg, partner_next;
    logic [ID_W-1:0] pend_reg, pend_next;
    logic            failed_reg, failed_next;
    logic [15:0]     idle_reg, idle_next;

    // stamp store, written per slot, no reset
    logic [TS_W-1:0] stamp_reg [6];
    logic [5:0]      st_we;
    logic [TS_W-1:0] st_wd [6];

    result_t         res_reg, res_next, res;
    logic            accept;
    logic            res_valid;
    logic            need_range;
    logic            restart;
    logic [2:0]      restart_ev;
    logic [31:0]     restart_range;
    logic [15:0]     idle_inc;
    logic [TS_W-1:0] delayed_stamp;
    logic [TS_W-1:0] round1, round2, reply1, reply2;
    range_status_t   rstat;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign delayed_stamp = stamp + reply_delay_reg;
    assign idle_inc      = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;

    // interval differences, modulo the stamp width
    assign round1 = payload_b - payload_a;
    assign reply1 = stamp_reg[S_R1_TX] - stamp_reg[S_INIT_RX];
    assign round2 = stamp - stamp_reg[S_R1_TX];
    assign reply2 = payload_c - payload_b;

    // event decode
    always_comb
    begin
        exp_next      = exp_reg;
        last_tx_next  = last_tx_reg;
        partner_next  = partner_reg;
        pend_next     = pend_reg;
        failed_next   = failed_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        need_range    = 1'b0;
        restart       = 1'b0;
        restart_ev    = EV_NONE;
        restart_range = '0;
        res           = '0;
        st_we         = '0;
        for (int i = 0; i < 6; i++)
        begin
            st_wd[i] = stamp;
        end

        if (accept)
        begin
            case (operation)
                OP_REQUEST:
                    pend_next = requested_peer;
                OP_TX_DONE:
                begin
                    case (last_tx_reg)
                        MSG_INIT:
                        begin
                            st_we[S_INIT_TX] = 1'b1;
                            idle_next        = '0;
                        end
                        MSG_REPLY1:
                        begin
                            st_we[S_R1_TX] = 1'b1;
                            idle_next      = '0;
                        end
                        MSG_REPLY2:
                        begin
                            st_we[S_R2_TX] = 1'b1;
                            idle_next      = '0;
                        end
                        MSG_REPORT, MSG_FAILED:
                        begin
                            exp_next  = MSG_INIT;
                            idle_next = '0;
                        end
                        default:
                            idle_next = idle_reg;
                    endcase
                end
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    if (idle_inc > reset_ms_reg)
                    begin
                        restart    = 1'b1;
                        restart_ev = EV_TIMEOUT;
                    end
                end
                default:
                begin
                    // received frame, handled only when addressed to us
                    if (target_id == own_id_reg)
                    begin
                        if (msg_type != exp_reg && msg_type != MSG_INIT
                            && !(msg_type == MSG_FAILED && exp_reg == MSG_REPORT))
                        begin
                            exp_next       = MSG_INIT;
                            res_valid      = 1'b1;
                            res.event_code = EV_UNEXP;
                        end
                        else if ((msg_type == MSG_REPLY1 || msg_type == MSG_REPLY2
                                  || msg_type == MSG_REPORT) && sender_id != partner_reg)
                        begin
                            failed_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.event_code = EV_MISMATCH;
                        end
                        else
                        begin
                            case (msg_type)
                                MSG_INIT:
                                begin
                                    partner_next     = sender_id;
                                    failed_next      = 1'b0;
                                    st_we[S_INIT_RX] = 1'b1;
                                    last_tx_next     = MSG_REPLY1;
                                    exp_next         = MSG_REPLY2;
                                    idle_next        = '0;
                                    res_valid        = 1'b1;
                                    res.tx_request   = 1'b1;
                                    res.tx_type      = MSG_REPLY1;
                                    res.tx_target    = sender_id;
                                    res.tx_delayed   = 1'b1;
                                end
                                MSG_REPLY1:
                                begin
                                    st_we[S_R1_RX] = 1'b1;
                                    st_we[S_R2_TX] = 1'b1;
                                    st_wd[S_R2_TX] = delayed_stamp;
                                    last_tx_next   = MSG_REPLY2;
                                    exp_next       = MSG_REPORT;
                                    idle_next      = '0;
                                    res_valid      = 1'b1;
                                    res.tx_request = 1'b1;
                                    res.tx_type    = MSG_REPLY2;
                                    res.tx_target  = partner_reg;
                                    res.tx_delayed = 1'b1;
                                    res.tx_word_a  = stamp_reg[S_INIT_TX];
                                    res.tx_word_b  = stamp;
                                    res.tx_word_c  = delayed_stamp;
                                end
                                MSG_REPLY2:
                                begin
                                    st_we[S_R2_RX] = 1'b1;
                                    exp_next       = MSG_INIT;
                                    idle_next      = '0;
                                    res.tx_request = 1'b1;
                                    res.tx_target  = partner_reg;
                                    if (!failed_reg)
                                    begin
                                        st_we[S_INIT_TX] = 1'b1;
                                        st_wd[S_INIT_TX] = payload_a;
                                        st_we[S_R1_RX]   = 1'b1;
                                        st_wd[S_R1_RX]   = payload_b;
                                        st_we[S_R2_TX]   = 1'b1;
                                        st_wd[S_R2_TX]   = payload_c;
                                        last_tx_next     = MSG_REPORT;
                                        need_range       = 1'b1;
                                        res.tx_type      = MSG_REPORT;
                                        res.event_code   = EV_RANGE;
                                    end
                                    else
                                    begin
                                        last_tx_next = MSG_FAILED;
                                        res_valid    = 1'b1;
                                        res.tx_type  = MSG_FAILED;
                                    end
                                end
                                MSG_REPORT:
                                begin
                                    restart       = 1'b1;
                                    restart_ev    = EV_REPORT;
                                    restart_range = (payload_a[TS_W-1:32] != '0)
                                                  ? 32'hFFFF_FFFF : payload_a[31:0];
                                end
                                default:
                                begin
                                    restart    = 1'b1;
                                    restart_ev = EV_FAILED;
                                end
                            endcase
                        end
                    end
                end
            endcase

            // restart the exchange, then open a new one if a peer is waiting
            if (restart)
            begin
                exp_next       = MSG_INIT;
                idle_next      = '0;
                res_valid      = 1'b1;
                res.event_code = restart_ev;
                res.dist_um    = restart_range;
                if (pend_reg != '0)
                begin
                    partner_next   = pend_reg;
                    pend_next      = '0;
                    last_tx_next   = MSG_INIT;
                    exp_next       = MSG_REPLY1;
                    res.tx_request = 1'b1;
                    res.tx_type    = MSG_INIT;
                    res.tx_target  = pend_reg;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (need_range)
                    state_next = ST_RANGE;
                else if (res_valid)
                    state_next = ST_OUT;
            ST_RANGE:
                if (rstat.done)
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result register load
    always_comb
    begin
        res_next = res_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    res_next = res;
            ST_RANGE:
                if (rstat.done)
                begin
                    res_next.tx_word_a = TS_W'(rstat.um);
                    res_next.dist_um   = rstat.um;
                    res_next.tof_ticks = rstat.tof;
                end
            default:
                res_next = res_reg;
        endcase
    end

    twr_range u_range (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (need_range),
        .round1 (round1),
        .round2 (round2),
        .reply1 (reply1),
        .reply2 (reply2),
        .status (rstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg      <= '0;
            reply_delay_reg <= '0;
            reset_ms_reg    <= 16'd250;
            state_reg       <= ST_IDLE;
            exp_reg         <= MSG_INIT;
            last_tx_reg     <= MSG_INIT;
            partner_reg     <= '0;
            pend_reg        <= '0;
            failed_reg      <= 1'b0;
            idle_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OWN_ID:      own_id_reg      <= cfg_data[ID_W-1:0];
                    CFG_REPLY_DELAY: reply_delay_reg <= cfg_data;
                    CFG_RESET_MS:    reset_ms_reg    <= cfg_data[15:0];
                    default:         reset_ms_reg    <= reset_ms_reg;
                endcase
            end
            state_reg   <= state_next;
            exp_reg     <= exp_next;
            last_tx_reg <= last_tx_next;
            partner_reg <= partner_next;
            pend_reg    <= pend_next;
            failed_reg  <= failed_next;
            idle_reg    <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        for (int i = 0; i < 6; i++)
        begin
            if (st_we[i])
                stamp_reg[i] <= st_wd[i];
        end
    end

    assign tx_request = res_reg.tx_request;
    assign tx_type    = res_reg.tx_type;
    assign tx_target  = res_reg.tx_target;
    assign tx_delayed = res_reg.tx_delayed;
    assign tx_word_a  = res_reg.tx_word_a;
    assign tx_word_b  = res_reg.tx_word_b;
    assign tx_word_c  = res_reg.tx_word_c;
    assign event_code = res_reg.event_code;
    assign dist_um    = res_reg.dist_um;
    assign tof_ticks  = res_reg.tof_ticks;

endmodule

[rtl/core/twr_checker.sv]
module twr_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     tx_request,
    input logic [2:0]               tx_type,
    input logic [twr_pkg::ID_W-1:0] tx_target,
    input logic [2:0]               event_code
);
    import twr_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // no new event while a result waits
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // idle transmit fields are zero
    a_no_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_request |-> tx_type == MSG_INIT && tx_target == '0)
        else $error("transmit fields set without request");

    // a computed range always goes out as a report
    a_range_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_RANGE |-> tx_request && tx_type == MSG_REPORT)
        else $error("range event without report");

endmodule

bind two_way_ranging_protocol_engine_core twr_checker u_twr_checker (.*);

[verif/tb_top.sv]
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twr_pkg::*;

    // one input event as the sender presents it
    typedef struct {
        logic [1:0]      op;
        logic [2:0]      msg;
        logic [ID_W-1:0] sender;
        logic [ID_W-1:0] target;
        logic [TS_W-1:0] stamp;
        logic [TS_W-1:0] pa;
        logic [TS_W-1:0] pb;
        logic [TS_W-1:0] pc;
        logic [ID_W-1:0] peer;
    } radio_event_t;

    localparam logic [TS_W-1:0] TS_ONES = {TS_W{1'b1}};
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 300;

    logic clk;
    logic rst_n;

    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_index;
    logic [TS_W-1:0] cfg_data;

    logic            in_valid;
    logic            in_stall;
    logic [1:0]      operation;
    logic [2:0]      msg_type;
    logic [ID_W-1:0] sender_id;
    logic [ID_W-1:0] target_id;
    logic [TS_W-1:0] stamp;
    logic [TS_W-1:0] payload_a;
    logic [TS_W-1:0] payload_b;
    logic [TS_W-1:0] payload_c;
    logic [ID_W-1:0] requested_peer;

    logic            out_valid;
    logic            out_stall;
    logic            tx_request;
    logic [2:0]      tx_type;
    logic [ID_W-1:0] tx_target;
    logic            tx_delayed;
    logic [TS_W-1:0] tx_word_a;
    logic [TS_W-1:0] tx_word_b;
    logic [TS_W-1:0] tx_word_c;
    logic [2:0]      event_code;
    logic [31:0]     dist_um;
    logic [TS_W-1:0] tof_ticks;

    two_way_ranging_protocol_engine_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .msg_type       (msg_type),
        .sender_id      (sender_id),
        .target_id      (target_id),
        .stamp          (stamp),
        .payload_a      (payload_a),
        .payload_b      (payload_b),
        .payload_c      (payload_c),
        .requested_peer (requested_peer),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_request     (tx_request),
        .tx_type        (tx_type),
        .tx_target      (tx_target),
        .tx_delayed     (tx_delayed),
        .tx_word_a      (tx_word_a),
        .tx_word_b      (tx_word_b),
        .tx_word_c      (tx_word_c),
        .event_code     (event_code),
        .dist_um        (dist_um),
        .tof_ticks      (tof_ticks)
    );

    // ------------------------------------------------------------------
    // shadow copy of the engine: configuration, protocol state, stamps
    // ------------------------------------------------------------------
    logic [ID_W-1:0] my_id;
    logic [TS_W-1:0] turn_delay;
    logic [15:0]     idle_limit_ms;
    logic [2:0]      want_msg;
    logic [2:0]      sent_type;
    logic [ID_W-1:0] partner;
    logic [ID_W-1:0] queued_peer;
    logic            exchange_broken;
    logic [15:0]     quiet_ms;
    logic [TS_W-1:0] stamps [6];
    bit              stamp_known [6];

    result_t frames_due[$];    // expected results, oldest first
    int      mismatches;
    bit      no_gaps;          // stretch with neither side idling
    int      rx_hold;          // long receiver hold-off, in cycles
    int      quiet_cycles;     // watchdog: cycles since the last transfer

    // time of flight from the four round and reply intervals
    function automatic logic [TS_W-1:0] flight_ticks();
        logic [TS_W-1:0] round1;
        logic [TS_W-1:0] reply1;
        logic [TS_W-1:0] round2;
        logic [TS_W-1:0] reply2;
        logic [79:0]     prod_a;
        logic [79:0]     prod_b;
        logic [41:0]     den;
        logic [79:0]     quo;
        round1 = stamps[S_R1_RX] - stamps[S_INIT_TX];
        reply1 = stamps[S_R1_TX] - stamps[S_INIT_RX];
        round2 = stamps[S_R2_RX] - stamps[S_R1_TX];
        reply2 = stamps[S_R2_TX] - stamps[S_R1_RX];
        prod_a = 80'(round1) * 80'(round2);
        prod_b = 80'(reply1) * 80'(reply2);
        den = 42'(round1) + 42'(round2) + 42'(reply1) + 42'(reply2);
        if (prod_a < prod_b || den == 0)
            return '0;
        quo = (prod_a - prod_b) / 80'(den);
        return quo[TS_W-1:0];
    endfunction

    // rounded micrometres, clipped to 32 bits
    function automatic logic [31:0] ticks_to_um(input logic [TS_W-1:0] tof);
        logic [127:0] p;
        p = 128'(tof) * 128'(UM_SCALE) + (128'd1 << 31);
        p = p >> 32;
        return (p > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    // abandon the exchange and open a new one if a peer is queued
    function automatic result_t restart_exchange(input logic [2:0] ev,
                                                 input logic [31:0] um);
        result_t r;
        r = '0;
        r.event_code = ev;
        r.dist_um = um;
        want_msg = MSG_INIT;
        quiet_ms = 0;
        if (queued_peer != 0) begin
            partner = queued_peer;
            queued_peer = 0;
            sent_type = MSG_INIT;
            want_msg = MSG_REPLY1;
            r.tx_request = 1'b1;
            r.tx_type = MSG_INIT;
            r.tx_target = partner;
        end
        return r;
    endfunction

    function automatic void note_stamp(input int slot, input logic [TS_W-1:0] v);
        stamps[slot] = v;
        stamp_known[slot] = 1'b1;
    endfunction

    // a frame that the engine takes in its own exchange (not ignored or rejected)
    function automatic bit frame_taken(input radio_event_t e);
        if (e.op != OP_FRAME || e.target != my_id)
            return 1'b0;
        if (e.msg != want_msg && e.msg != MSG_INIT &&
            !(e.msg == MSG_FAILED && want_msg == MSG_REPORT))
            return 1'b0;
        if ((e.msg == MSG_REPLY1 || e.msg == MSG_REPLY2 || e.msg == MSG_REPORT) &&
            e.sender != partner)
            return 1'b0;
        return 1'b1;
    endfunction

    // true when the event would use a stamp slot that was never filled
    function automatic bit needs_blank_stamp(input radio_event_t e);
        if (!frame_taken(e))
            return 1'b0;
        if (e.msg == MSG_REPLY1)
            return !stamp_known[S_INIT_TX];
        if (e.msg == MSG_REPLY2 && !exchange_broken)
            return !(stamp_known[S_INIT_RX] && stamp_known[S_R1_TX]);
        return 1'b0;
    endfunction

    // advance the shadow engine by one event, return 1 with the result if any
    function automatic bit ranging_step(input radio_event_t e, output result_t r);
        logic [TS_W-1:0] tof;
        logic [31:0]     um;
        r = '0;
        case (e.op)
            OP_REQUEST:
            begin
                queued_peer = e.peer;
                return 1'b0;
            end
            OP_TX_DONE:
            begin
                case (sent_type)
                    MSG_INIT:   begin note_stamp(S_INIT_TX, e.stamp); quiet_ms = 0; end
                    MSG_REPLY1: begin note_stamp(S_R1_TX, e.stamp); quiet_ms = 0; end
                    MSG_REPLY2: begin note_stamp(S_R2_TX, e.stamp); quiet_ms = 0; end
                    MSG_REPORT, MSG_FAILED:
                    begin
                        want_msg = MSG_INIT;
                        quiet_ms = 0;
                    end
                    default: ;
                endcase
                return 1'b0;
            end
            OP_TICK:
            begin
                if (quiet_ms != 16'hFFFF)
                    quiet_ms++;
                if (quiet_ms > idle_limit_ms) begin
                    r = restart_exchange(EV_TIMEOUT, '0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: ;
        endcase

        // received frame
        if (e.target != my_id)
            return 1'b0;
        if (e.msg != want_msg && e.msg != MSG_INIT &&
            !(e.msg == MSG_FAILED && want_msg == MSG_REPORT)) begin
            want_msg = MSG_INIT;
            r.event_code = EV_UNEXP;
            return 1'b1;
        end
        if ((e.msg == MSG_REPLY1 || e.msg == MSG_REPLY2 || e.msg == MSG_REPORT) &&
            e.sender != partner) begin
            exchange_broken = 1'b1;
            r.event_code = EV_MISMATCH;
            return 1'b1;
        end
        case (e.msg)
            MSG_INIT:
            begin
                partner = e.sender;
                exchange_broken = 1'b0;
                note_stamp(S_INIT_RX, e.stamp);
                sent_type = MSG_REPLY1;
                want_msg = MSG_REPLY2;
                quiet_ms = 0;
                r.tx_request = 1'b1;
                r.tx_type = MSG_REPLY1;
                r.tx_target = partner;
                r.tx_delayed = 1'b1;
            end
            MSG_REPLY1:
            begin
                note_stamp(S_R1_RX, e.stamp);
                note_stamp(S_R2_TX, e.stamp + turn_delay);
                sent_type = MSG_REPLY2;
                want_msg = MSG_REPORT;
                quiet_ms = 0;
                r.tx_request = 1'b1;
                r.tx_type = MSG_REPLY2;
                r.tx_target = partner;
                r.tx_delayed = 1'b1;
                r.tx_word_a = stamps[S_INIT_TX];
                r.tx_word_b = stamps[S_R1_RX];
                r.tx_word_c = stamps[S_R2_TX];
            end
            MSG_REPLY2:
            begin
                note_stamp(S_R2_RX, e.stamp);
                want_msg = MSG_INIT;
                quiet_ms = 0;
                r.tx_request = 1'b1;
                r.tx_target = partner;
                if (!exchange_broken) begin
                    note_stamp(S_INIT_TX, e.pa);
                    note_stamp(S_R1_RX, e.pb);
                    note_stamp(S_R2_TX, e.pc);
                    tof = flight_ticks();
                    um = ticks_to_um(tof);
                    sent_type = MSG_REPORT;
                    r.tx_type = MSG_REPORT;
                    r.tx_word_a = TS_W'(um);
                    r.event_code = EV_RANGE;
                    r.dist_um = um;
                    r.tof_ticks = tof;
                end else begin
                    sent_type = MSG_FAILED;
                    r.tx_type = MSG_FAILED;
                end
            end
            MSG_REPORT:
                r = restart_exchange(EV_REPORT,
                                     (e.pa > 40'h00_FFFF_FFFF) ? 32'hFFFF_FFFF : e.pa[31:0]);
            default:
                r = restart_exchange(EV_FAILED, '0);
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: stall pattern and checking
    // ------------------------------------------------------------------
    int rx_wait;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_valid && !out_stall)
                check_frame();
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall && !no_gaps)
                    rx_wait = $urandom_range(0, 19);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_frame();
        result_t w;
        if (frames_due.size() == 0) begin
            report_mismatch("unexpected result", 64'(event_code), 64'(EV_NONE));
            return;
        end
        w = frames_due.pop_front();
        if (tx_request !== w.tx_request)
            report_mismatch("tx_request", 64'(tx_request), 64'(w.tx_request));
        if (tx_type !== w.tx_type)
            report_mismatch("tx_type", 64'(tx_type), 64'(w.tx_type));
        if (tx_target !== w.tx_target)
            report_mismatch("tx_target", 64'(tx_target), 64'(w.tx_target));
        if (tx_delayed !== w.tx_delayed)
            report_mismatch("tx_delayed", 64'(tx_delayed), 64'(w.tx_delayed));
        if (tx_word_a !== w.tx_word_a)
            report_mismatch("tx_word_a", 64'(tx_word_a), 64'(w.tx_word_a));
        if (tx_word_b !== w.tx_word_b)
            report_mismatch("tx_word_b", 64'(tx_word_b), 64'(w.tx_word_b));
        if (tx_word_c !== w.tx_word_c)
            report_mismatch("tx_word_c", 64'(tx_word_c), 64'(w.tx_word_c));
        if (event_code !== w.event_code)
            report_mismatch("event_code", 64'(event_code), 64'(w.event_code));
        if (dist_um !== w.dist_um)
            report_mismatch("dist_um", 64'(dist_um), 64'(w.dist_um));
        if (tof_ticks !== w.tof_ticks)
            report_mismatch("tof_ticks", 64'(tof_ticks), 64'(w.tof_ticks));
    endtask

    // ------------------------------------------------------------------
    // event side
    // ------------------------------------------------------------------
    // present one event, wait for its transfer, then update the shadow engine
    task automatic send_event(input radio_event_t e);
        int      gap;
        result_t r;
        if (needs_blank_stamp(e)) begin
            // keep clear of stamp slots that were never filled
            e.op = OP_TICK;
        end
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation      <= e.op;
        msg_type       <= e.msg;
        sender_id      <= e.sender;
        target_id      <= e.target;
        stamp          <= e.stamp;
        payload_a      <= e.pa;
        payload_b      <= e.pb;
        payload_c      <= e.pc;
        requested_peer <= e.peer;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (ranging_step(e, r))
            frames_due.push_back(r);
    endtask

    function automatic logic [TS_W-1:0] rand_ts();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TS_ONES;
            2:       return TS_W'($urandom_range(0, 4095));
            default: return TS_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic radio_event_t blank_event(input logic [1:0] op);
        radio_event_t e;
        e.op = op;
        e.msg = 3'($urandom);
        e.sender = ID_W'($urandom);
        e.target = ID_W'($urandom);
        e.stamp = rand_ts();
        e.pa = rand_ts();
        e.pb = rand_ts();
        e.pc = rand_ts();
        e.peer = ID_W'($urandom);
        return e;
    endfunction

    function automatic radio_event_t frame_event(input logic [2:0] msg,
                                                 input logic [ID_W-1:0] from,
                                                 input logic [ID_W-1:0] to,
                                                 input logic [TS_W-1:0] ts);
        radio_event_t e;
        e = blank_event(OP_FRAME);
        e.msg = msg;
        e.sender = from;
        e.target = to;
        e.stamp = ts;
        return e;
    endfunction

    // REPLY2 whose stamps agree with a true flight time of tof ticks
    function automatic radio_event_t clean_reply2(input logic [ID_W-1:0] from,
                                                  input logic [TS_W-1:0] tof);
        radio_event_t    e;
        logic [TS_W-1:0] turn;
        turn = TS_W'($urandom_range(0, 1000000));
        e = frame_event(MSG_REPLY2, from, my_id, '0);
        e.pa = stamps[S_INIT_RX] - tof;
        e.pb = stamps[S_R1_TX] + tof;
        e.pc = e.pb + turn;
        e.stamp = e.pc + tof;
        return e;
    endfunction

    task automatic send_op(input logic [1:0] op, input logic [TS_W-1:0] ts,
                           input logic [ID_W-1:0] peer);
        radio_event_t e;
        e = blank_event(op);
        e.stamp = ts;
        e.peer = peer;
        send_event(e);
    endtask

    // wait until every expected result has arrived and the engine has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TS_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_ID:      my_id = v[ID_W-1:0];
            CFG_REPLY_DELAY: turn_delay = v;
            default:         idle_limit_ms = v[15:0];
        endcase
    endtask

    task automatic configure(input logic [ID_W-1:0] id, input logic [TS_W-1:0] delay,
                             input logic [15:0] ms);
        wait_drained();
        write_reg(CFG_OWN_ID, TS_W'(id));
        write_reg(CFG_REPLY_DELAY, delay);
        write_reg(CFG_RESET_MS, TS_W'(ms));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // full exchanges as responder and as initiator, plus each corner case
    task automatic test_directed();
        logic [ID_W-1:0] peer_b;
        configure(8'hFF, 40'd12345, 16'd2);
        peer_b = 8'h77;

        // responder: INIT, its transmit done, consistent REPLY2 gives a range
        send_event(frame_event(MSG_INIT, peer_b, my_id, 40'h10_0000_0000));
        send_op(OP_TX_DONE, 40'h10_0001_0000, '0);
        send_event(clean_reply2(peer_b, 40'd300));
        send_op(OP_TX_DONE, TS_ONES, '0);

        // zero numerator: round2 and reply1 vanish, so both products are zero
        send_event(frame_event(MSG_INIT, peer_b, my_id, 40'h55));
        send_op(OP_TX_DONE, 40'h55, '0);
        send_event(frame_event(MSG_REPLY2, peer_b, my_id, 40'h55));

        // wrong partner marks the exchange failed, then REPLY2 sends FAILED
        send_event(frame_event(MSG_INIT, peer_b, my_id, TS_ONES));
        send_op(OP_TX_DONE, '0, '0);
        send_event(frame_event(MSG_REPLY2, 8'h01, my_id, '0));
        send_event(frame_event(MSG_REPLY2, peer_b, my_id, 40'h7));
        send_op(OP_TX_DONE, '0, '0);

        // negative numerator: inconsistent stamps
        send_event(frame_event(MSG_INIT, peer_b, my_id, 40'h100));
        send_op(OP_TX_DONE, 40'hF_0000, '0);
        send_event(frame_event(MSG_REPLY2, peer_b, my_id, 40'hF_0001));

        // initiator: queued peer, timeout sends INIT, then REPLY1 and a FAILED frame
        send_op(OP_REQUEST, '0, 8'h33);
        repeat (3) send_op(OP_TICK, '0, '0);
        send_op(OP_TX_DONE, 40'h20, '0);
        send_event(frame_event(MSG_REPLY1, 8'h33, my_id, TS_ONES));
        send_event(frame_event(MSG_FAILED, 8'h33, my_id, '0));

        // report carrying more than 32 bits of range, unknown type, foreign frame
        send_op(OP_REQUEST, '0, 8'h80);
        repeat (3) send_op(OP_TICK, '0, '0);
        send_event(frame_event(MSG_REPLY1, 8'h80, my_id, 40'h1234));
        begin
            radio_event_t e;
            e = frame_event(MSG_REPORT, 8'h80, my_id, '0);
            e.pa = TS_ONES;
            send_event(e);
        end
        send_event(frame_event(3'd7, 8'h80, my_id, '0));
        send_event(frame_event(MSG_INIT, 8'h80, 8'h00, '0));
    endtask

    // long tof to saturate the micrometre range
    task automatic test_range_limits();
        configure(8'h00, TS_ONES, 16'd1);
        send_event(frame_event(MSG_INIT, 8'hAA, my_id, 40'h80_0000_0000));
        send_op(OP_TX_DONE, 40'h80_0000_1000, '0);
        send_event(clean_reply2(8'hAA, 40'h3F_FFFF_FFFF));
    endtask

    // receiver holds off while events keep coming, then the sender waits out
    task automatic test_backpressure();
        configure(8'h42, 40'd1000, 16'd3);
        rx_hold = 400;
        no_gaps = 1'b1;
        repeat (12)
            send_event(frame_event(3'd5, 8'h01, my_id, '0));
        no_gaps = 1'b0;
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (4)
            send_event(frame_event(3'd6, 8'h01, my_id, '0));
    endtask

    function automatic radio_event_t shaped_event();
        radio_event_t e;
        int           pick;
        logic [2:0]   msg;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            e = blank_event(OP_REQUEST);
            if ($urandom_range(0, 4) == 0)
                e.peer = '0;
        end else if (pick < 22) begin
            e = blank_event(OP_TX_DONE);
        end else if (pick < 34) begin
            e = blank_event(OP_TICK);
        end else if (pick < 92) begin
            msg = ($urandom_range(0, 4) == 0) ? MSG_INIT : want_msg;
            if (msg == MSG_REPORT && $urandom_range(0, 3) == 0)
                msg = MSG_FAILED;
            e = frame_event(msg, ($urandom_range(0, 9) != 0) ? partner : ID_W'($urandom),
                            ($urandom_range(0, 12) != 0) ? my_id : ID_W'($urandom),
                            rand_ts());
            if (msg == MSG_REPLY2 && $urandom_range(0, 9) < 7)
                e = clean_reply2(e.sender, TS_W'($urandom_range(0, 200000)));
            if (msg == MSG_REPORT && $urandom_range(0, 1) == 0)
                e.pa = TS_W'($urandom);
        end else begin
            e = blank_event(OP_FRAME);
            e.op = 2'($urandom);
        end
        return e;
    endfunction

    task automatic test_random(input int n_events);
        for (int i = 0; i < n_events; i++) begin
            if (i % 60 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_event(shaped_event());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = '0;
        msg_type = '0;
        sender_id = '0;
        target_id = '0;
        stamp = '0;
        payload_a = '0;
        payload_b = '0;
        payload_c = '0;
        requested_peer = '0;
        out_stall = 1'b0;
        my_id = '0;
        turn_delay = '0;
        idle_limit_ms = 16'd250;
        want_msg = MSG_INIT;
        sent_type = MSG_INIT;
        partner = '0;
        queued_peer = '0;
        exchange_broken = 1'b0;
        quiet_ms = '0;
        foreach (stamps[i])
        begin
            stamps[i] = '0;
            stamp_known[i] = 1'b0;
        end
        mismatches = 0;
        no_gaps = 1'b0;
        rx_hold = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: own id 0 and a 250 ms idle limit
        send_event(frame_event(MSG_INIT, 8'h09, 8'h00, 40'h1));
        repeat (252) send_op(OP_TICK, '0, '0);

        test_directed();
        test_range_limits();
        test_backpressure();
        configure(8'h5A, TS_W'($urandom), 16'd4);
        test_random(200);
        configure(8'($urandom), TS_W'({$urandom, $urandom}), 16'($urandom_range(1, 6)));
        test_random(150);
        configure(8'hFF, '0, 16'hFFFF);
        test_random(75);
        configure(8'h00, TS_ONES, 16'd1);
        test_random(75);

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
